>>> src/rv32i_integer_execute_unit_macros.svh
// Assertion macros shared by the execute unit RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef RV32I_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define RV32I_INTEGER_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RVEX_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvex assertion failed");

// Next-cycle implication, checked outside reset.
`define RVEX_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvex assertion failed");

`endif

>>> src/rvex_pkg.sv
// Shared types and constants for the RV32I integer execute unit.
// No dependencies.
`default_nettype none

package rvex_pkg;

	localparam int unsigned XLEN      = 32;
	localparam int unsigned REG_COUNT = 32;
	localparam int unsigned REG_IDX_W = 5;
	localparam int unsigned MODE_W    = 5;
	localparam int unsigned IMM_W     = 20;
	localparam int unsigned IMM_I_W   = 12;
	localparam int unsigned SHAMT_W   = 5;
	localparam int unsigned PADDR_W   = 2;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [XLEN-1:0] START_ADDRESS_RESET = '0;
	localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 5'd0,
		MODE_SUB   = 5'd1,
		MODE_SLL   = 5'd2,
		MODE_SLT   = 5'd3,
		MODE_SLTU  = 5'd4,
		MODE_XOR   = 5'd5,
		MODE_SRL   = 5'd6,
		MODE_SRA   = 5'd7,
		MODE_OR    = 5'd8,
		MODE_AND   = 5'd9,
		MODE_ADDI  = 5'd10,
		MODE_SLLI  = 5'd11,
		MODE_SLTI  = 5'd12,
		MODE_SLTIU = 5'd13,
		MODE_XORI  = 5'd14,
		MODE_SRLI  = 5'd15,
		MODE_SRAI  = 5'd16,
		MODE_ORI   = 5'd17,
		MODE_ANDI  = 5'd18,
		MODE_BEQ   = 5'd19,
		MODE_BNE   = 5'd20,
		MODE_BLT   = 5'd21,
		MODE_BGE   = 5'd22,
		MODE_BLTU  = 5'd23,
		MODE_BGEU  = 5'd24,
		MODE_JAL   = 5'd25,
		MODE_JALR  = 5'd26
	} mode_t;

	typedef enum logic [3:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_SLL,
		ALU_SLT,
		ALU_SLTU,
		ALU_XOR,
		ALU_SRL,
		ALU_SRA,
		ALU_OR,
		ALU_AND
	} alu_op_t;

	typedef enum logic [PADDR_W-1:0] {
		REG_START_ADDRESS = 2'd0
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> src/rvex_in_if.sv
// Instruction channel of the execute unit: valid/ready plus decoded fields.
// Depends on rvex_pkg.
`default_nettype none

interface rvex_in_if import rvex_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [REG_IDX_W-1:0] dest_reg;
	logic [REG_IDX_W-1:0] src1_reg;
	logic [REG_IDX_W-1:0] src2_reg;
	logic [IMM_W-1:0]     immediate;

	modport source (output valid, mode, dest_reg, src1_reg, src2_reg, immediate, input ready);
	modport sink   (input valid, mode, dest_reg, src1_reg, src2_reg, immediate, output ready);
endinterface

`default_nettype wire

>>> src/rvex_out_if.sv
// Result channel of the execute unit: valid/ready plus write-back and next PC.
// Depends on rvex_pkg.
`default_nettype none

interface rvex_out_if import rvex_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 write_enable;
	logic [REG_IDX_W-1:0] write_index;
	logic [XLEN-1:0]      write_value;
	logic                 branch_taken;
	logic [XLEN-1:0]      next_address;

	modport source (output valid, write_enable, write_index, write_value, branch_taken,
		next_address, input ready);
	modport sink   (input valid, write_enable, write_index, write_value, branch_taken,
		next_address, output ready);
endinterface

`default_nettype wire

>>> src/rv32i_integer_execute_unit.sv
// Top level of the RV32I integer execute unit: register file, PC, ALU, branch unit.
// Depends on rvex_pkg, rvex_in_if, rvex_out_if and the assertion macro header.
//
// Channel   Direction  Handshake     Beat contents
// issue     in         valid/ready   mode, dest_reg, src1_reg, src2_reg, immediate
// result    out        valid/ready   write_enable, write_index, write_value,
//                                    branch_taken, next_address
// apb       in         psel/penable  start_address register at every byte address
//
// An accepted instruction is registered in the execute stage, then in the result register,
// and one is accepted every cycle while the result is not stalled. Operands are read
// from the register file at accept, with the value being written back in the same cycle
// forwarded around it. Reset clears the register file through per-entry valid bits and
// sets the PC to zero. A stalled result holds the execute stage, which drops issue ready.
`default_nettype none
`include "rv32i_integer_execute_unit_macros.svh"

module rv32i_integer_execute_unit import rvex_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rvex_in_if.sink                 issue,
	rvex_out_if.source              result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	logic [XLEN-1:0] start_q;
	logic [XLEN-1:0] pc_q;
	logic [XLEN-1:0] regs_mem [REG_COUNT];
	logic [REG_COUNT-1:0] reg_vld_q;

	logic                 vld_s1;
	mode_t                mode_s1;
	logic [REG_IDX_W-1:0] rd_s1;
	logic [IMM_W-1:0]     imm_s1;
	logic [XLEN-1:0]      a_s1;
	logic [XLEN-1:0]      b_s1;

	logic                 res_vld_q;
	logic                 res_we_q;
	logic [REG_IDX_W-1:0] res_idx_q;
	logic [XLEN-1:0]      res_val_q;
	logic                 res_taken_q;
	logic [XLEN-1:0]      res_next_q;

	logic            accept;
	logic            adv;
	logic            cfg_wr;
	logic            fwd1;
	logic            fwd2;
	logic            wr;
	logic            wr_eff;
	logic            taken;
	logic            cond;
	logic            use_imm;
	alu_op_t         op;
	logic [XLEN-1:0] imm_i;
	logic [XLEN-1:0] imm_b;
	logic [XLEN-1:0] imm_j;
	logic [XLEN-1:0] alu_b;
	logic [XLEN-1:0] alu_res;
	logic [XLEN-1:0] val;
	logic [XLEN-1:0] next;
	logic [XLEN-1:0] jalr_sum;
	logic [SHAMT_W-1:0] sh;

	assign pready = 1'b1;
	assign prdata = start_q;
	assign cfg_wr = psel && penable && pwrite && pready && (cfg_reg_t'(paddr) == REG_START_ADDRESS
		|| paddr != '0);

	assign adv          = vld_s1 && (!res_vld_q || result.ready);
	assign issue.ready  = !vld_s1 || adv;
	assign accept       = issue.valid && issue.ready;

	assign imm_i = {{(XLEN-IMM_I_W){imm_s1[IMM_I_W-1]}}, imm_s1[IMM_I_W-1:0]};
	assign imm_b = {{(XLEN-IMM_I_W-1){imm_s1[IMM_I_W-1]}}, imm_s1[IMM_I_W-1:0], 1'b0};
	assign imm_j = {{(XLEN-IMM_W-1){imm_s1[IMM_W-1]}}, imm_s1, 1'b0};

	always_comb begin
		use_imm = 1'b1;
		op      = ALU_ADD;
		case (mode_s1)
			MODE_ADD:   begin use_imm = 1'b0; op = ALU_ADD;  end
			MODE_SUB:   begin use_imm = 1'b0; op = ALU_SUB;  end
			MODE_SLL:   begin use_imm = 1'b0; op = ALU_SLL;  end
			MODE_SLT:   begin use_imm = 1'b0; op = ALU_SLT;  end
			MODE_SLTU:  begin use_imm = 1'b0; op = ALU_SLTU; end
			MODE_XOR:   begin use_imm = 1'b0; op = ALU_XOR;  end
			MODE_SRL:   begin use_imm = 1'b0; op = ALU_SRL;  end
			MODE_SRA:   begin use_imm = 1'b0; op = ALU_SRA;  end
			MODE_OR:    begin use_imm = 1'b0; op = ALU_OR;   end
			MODE_AND:   begin use_imm = 1'b0; op = ALU_AND;  end
			MODE_ADDI:  op = ALU_ADD;
			MODE_SLLI:  op = ALU_SLL;
			MODE_SLTI:  op = ALU_SLT;
			MODE_SLTIU: op = ALU_SLTU;
			MODE_XORI:  op = ALU_XOR;
			MODE_SRLI:  op = ALU_SRL;
			MODE_SRAI:  op = ALU_SRA;
			MODE_ORI:   op = ALU_OR;
			MODE_ANDI:  op = ALU_AND;
			default:    op = ALU_ADD;
		endcase
	end

	assign alu_b = use_imm ? imm_i : b_s1;
	assign sh    = alu_b[SHAMT_W-1:0];

	always_comb begin
		case (op)
			ALU_ADD:  alu_res = a_s1 + alu_b;
			ALU_SUB:  alu_res = a_s1 - alu_b;
			ALU_SLL:  alu_res = a_s1 << sh;
			ALU_SLT:  alu_res = XLEN'($signed(a_s1) < $signed(alu_b));
			ALU_SLTU: alu_res = XLEN'(a_s1 < alu_b);
			ALU_XOR:  alu_res = a_s1 ^ alu_b;
			ALU_SRL:  alu_res = a_s1 >> sh;
			ALU_SRA:  alu_res = XLEN'($signed(a_s1) >>> sh);
			ALU_OR:   alu_res = a_s1 | alu_b;
			ALU_AND:  alu_res = a_s1 & alu_b;
			default:  alu_res = a_s1 & alu_b;
		endcase
	end

	always_comb begin
		case (mode_s1)
			MODE_BEQ:  cond = (a_s1 == b_s1);
			MODE_BNE:  cond = (a_s1 != b_s1);
			MODE_BLT:  cond = ($signed(a_s1) < $signed(b_s1));
			MODE_BGE:  cond = !($signed(a_s1) < $signed(b_s1));
			MODE_BLTU: cond = (a_s1 < b_s1);
			MODE_BGEU: cond = !(a_s1 < b_s1);
			default:   cond = 1'b0;
		endcase
	end

	assign jalr_sum = a_s1 + imm_i;

	always_comb begin
		wr    = 1'b0;
		taken = 1'b0;
		val   = alu_res;
		next  = pc_q + PC_STEP;
		case (mode_s1)
			MODE_JAL: begin
				wr    = 1'b1;
				taken = 1'b1;
				val   = pc_q + PC_STEP;
				next  = pc_q + imm_j;
			end
			MODE_JALR: begin
				wr    = 1'b1;
				taken = 1'b1;
				val   = pc_q + PC_STEP;
				next  = {jalr_sum[XLEN-1:1], 1'b0};
			end
			MODE_BEQ, MODE_BNE, MODE_BLT, MODE_BGE, MODE_BLTU, MODE_BGEU: begin
				taken = cond;
				if (cond) begin
					next = pc_q + imm_b;
				end
			end
			default: begin
				wr = (mode_s1 <= MODE_ANDI);
			end
		endcase
	end

	assign wr_eff = wr && (rd_s1 != '0);
	assign fwd1   = adv && wr_eff && (rd_s1 == issue.src1_reg);
	assign fwd2   = adv && wr_eff && (rd_s1 == issue.src2_reg);

	always_ff @(posedge clk) begin
		if (adv && wr_eff) begin
			regs_mem[rd_s1] <= val;
		end
		if (accept) begin
			mode_s1 <= mode_t'(issue.mode);
			rd_s1   <= issue.dest_reg;
			imm_s1  <= issue.immediate;
			a_s1    <= fwd1 ? val : (reg_vld_q[issue.src1_reg] ? regs_mem[issue.src1_reg] : '0);
			b_s1    <= fwd2 ? val : (reg_vld_q[issue.src2_reg] ? regs_mem[issue.src2_reg] : '0);
		end
		if (adv) begin
			res_we_q    <= wr_eff;
			res_idx_q   <= wr_eff ? rd_s1 : '0;
			res_val_q   <= wr_eff ? val : '0;
			res_taken_q <= taken;
			res_next_q  <= next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= START_ADDRESS_RESET;
			pc_q      <= START_ADDRESS_RESET;
			reg_vld_q <= '0;
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				start_q <= pwdata[XLEN-1:0];
				pc_q    <= pwdata[XLEN-1:0];
			end else if (adv) begin
				pc_q <= next;
			end
			if (adv && wr_eff) begin
				reg_vld_q[rd_s1] <= 1'b1;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign result.valid        = res_vld_q;
	assign result.write_enable = res_we_q;
	assign result.write_index  = res_idx_q;
	assign result.write_value  = res_val_q;
	assign result.branch_taken = res_taken_q;
	assign result.next_address = res_next_q;

	`RVEX_ASSERT_IMP(a_no_x0_write, res_vld_q && res_we_q, res_idx_q != '0)
	`RVEX_ASSERT_IMP(a_quiet_no_write, res_vld_q && !res_we_q, res_val_q == '0 && res_idx_q == '0)
	`RVEX_ASSERT_NXT(a_accept_fills_s1, accept, vld_s1)
	`RVEX_ASSERT_NXT(a_pc_tracks_result, adv && !cfg_wr, pc_q == res_next_q && res_vld_q)

endmodule

`default_nettype wire

>>> dv/rvex_retire_checker.sv
// Checker for the RV32I integer execute unit: watches the issue, result and APB ports,
// keeps its own register file and PC, and compares every result beat in order.
// Depends on rvex_pkg, rvex_in_if and rvex_out_if.

module rvex_retire_checker import rvex_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rvex_in_if                      issue,
	rvex_out_if                     result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic               pready,
	output int unsigned             err_count,
	output int unsigned             pending
);

	typedef struct packed {
		logic                 we;
		logic [REG_IDX_W-1:0] idx;
		logic [XLEN-1:0]      val;
		logic                 taken;
		logic [XLEN-1:0]      next;
	} retire_t;

	localparam logic [PADDR_W-1:0] START_ADDR_OFFSET = PADDR_W'(4 * int'(REG_START_ADDRESS));

	logic [XLEN-1:0] gpr [REG_COUNT];
	logic [XLEN-1:0] pc_model;
	logic [XLEN-1:0] boot_addr;
	retire_t         retire_q [$];
	int unsigned     errs;

	function automatic alu_op_t alu_sel(logic [MODE_W-1:0] mode);
		case (mode_t'(mode))
		MODE_SUB:              return ALU_SUB;
		MODE_SLL, MODE_SLLI:   return ALU_SLL;
		MODE_SLT, MODE_SLTI:   return ALU_SLT;
		MODE_SLTU, MODE_SLTIU: return ALU_SLTU;
		MODE_XOR, MODE_XORI:   return ALU_XOR;
		MODE_SRL, MODE_SRLI:   return ALU_SRL;
		MODE_SRA, MODE_SRAI:   return ALU_SRA;
		MODE_OR, MODE_ORI:     return ALU_OR;
		MODE_AND, MODE_ANDI:   return ALU_AND;
		default:               return ALU_ADD;
		endcase
	endfunction

	function automatic logic [XLEN-1:0] alu_eval(alu_op_t op, logic [XLEN-1:0] a,
		logic [XLEN-1:0] b);
		logic [SHAMT_W-1:0] sh;
		sh = b[SHAMT_W-1:0];
		case (op)
		ALU_ADD:  return a + b;
		ALU_SUB:  return a - b;
		ALU_SLL:  return a << sh;
		ALU_SLT:  return XLEN'($signed(a) < $signed(b));
		ALU_SLTU: return XLEN'(a < b);
		ALU_XOR:  return a ^ b;
		ALU_SRL:  return a >> sh;
		ALU_SRA:  return $unsigned($signed(a) >>> sh);
		ALU_OR:   return a | b;
		default:  return a & b;
		endcase
	endfunction

	function automatic retire_t execute(logic [MODE_W-1:0] mode, logic [REG_IDX_W-1:0] rd,
		logic [IMM_W-1:0] imm, logic [XLEN-1:0] a, logic [XLEN-1:0] b, logic [XLEN-1:0] pc);
		retire_t         r;
		logic [XLEN-1:0] imm_i;
		logic [XLEN-1:0] jal_off;
		logic [XLEN-1:0] val;
		logic            wr;
		logic            cond;
		imm_i   = {{(XLEN-IMM_I_W){imm[IMM_I_W-1]}}, imm[IMM_I_W-1:0]};
		jal_off = {{(XLEN-IMM_W-1){imm[IMM_W-1]}}, imm, 1'b0};
		val     = '0;
		wr      = 1'b0;
		cond    = 1'b0;
		r.taken = 1'b0;
		r.next  = pc + PC_STEP;
		case (mode_t'(mode))
		MODE_ADD, MODE_SUB, MODE_SLL, MODE_SLT, MODE_SLTU, MODE_XOR, MODE_SRL, MODE_SRA,
		MODE_OR, MODE_AND: begin
			val = alu_eval(alu_sel(mode), a, b);
			wr  = 1'b1;
		end
		MODE_ADDI, MODE_SLLI, MODE_SLTI, MODE_SLTIU, MODE_XORI, MODE_SRLI, MODE_SRAI,
		MODE_ORI, MODE_ANDI: begin
			val = alu_eval(alu_sel(mode), a, imm_i);
			wr  = 1'b1;
		end
		MODE_BEQ, MODE_BNE, MODE_BLT, MODE_BGE, MODE_BLTU, MODE_BGEU: begin
			case (mode_t'(mode))
			MODE_BEQ:  cond = (a == b);
			MODE_BNE:  cond = (a != b);
			MODE_BLT:  cond = ($signed(a) < $signed(b));
			MODE_BGE:  cond = !($signed(a) < $signed(b));
			MODE_BLTU: cond = (a < b);
			default:   cond = !(a < b);
			endcase
			if (cond) begin
				r.next  = pc + {imm_i[XLEN-2:0], 1'b0};
				r.taken = 1'b1;
			end
		end
		MODE_JAL: begin
			val     = pc + PC_STEP;
			wr      = 1'b1;
			r.next  = pc + jal_off;
			r.taken = 1'b1;
		end
		MODE_JALR: begin
			val     = pc + PC_STEP;
			wr      = 1'b1;
			r.next  = (a + imm_i) & ~XLEN'(1);
			r.taken = 1'b1;
		end
		default: ;
		endcase
		if (rd == '0)
			wr = 1'b0;
		r.we  = wr;
		r.idx = wr ? rd : '0;
		r.val = wr ? val : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		retire_t want;
		retire_t got;
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				gpr[i] = '0;
			boot_addr = START_ADDRESS_RESET;
			pc_model  = START_ADDRESS_RESET;
			retire_q.delete();
			pending   <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got = '{result.write_enable, result.write_index, result.write_value,
					result.branch_taken, result.next_address};
				if (retire_q.size() == 0) begin
					errs = errs + 1;
					if (errs <= 10)
						$display("unexpected result beat: we=%0d idx=%0d val=%h taken=%0d next=%h",
							got.we, got.idx, got.val, got.taken, got.next);
				end else begin
					want = retire_q.pop_front();
					if (got !== want) begin
						errs = errs + 1;
						if (errs <= 10) begin
							$display("result mismatch: expected we=%0d idx=%0d val=%h taken=%0d next=%h",
								want.we, want.idx, want.val, want.taken, want.next);
							$display("                 got      we=%0d idx=%0d val=%h taken=%0d next=%h",
								got.we, got.idx, got.val, got.taken, got.next);
						end
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == START_ADDR_OFFSET) begin
				boot_addr = pwdata[XLEN-1:0];
				pc_model  = boot_addr;
			end
			if (issue.valid && issue.ready) begin
				want = execute(issue.mode, issue.dest_reg, issue.immediate,
					gpr[issue.src1_reg], gpr[issue.src2_reg], pc_model);
				if (want.we)
					gpr[want.idx] = want.val;
				pc_model = want.next;
				retire_q.push_back(want);
			end
			pending <= retire_q.size();
		end
		err_count <= errs;
	end

	initial begin
		errs      = 0;
		err_count = 0;
		pending   = 0;
	end

endmodule

>>> dv/tb_rv32i_integer_execute_unit.sv
// Testbench top for the RV32I integer execute unit: clock, reset, APB setup of the
// start address, directed and random instruction beats, and the final verdict.
// Depends on rvex_pkg, rvex_in_if, rvex_out_if, the block and rvex_retire_checker.

module tb_rv32i_integer_execute_unit;
	import rvex_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 5'd27;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 5'd31;
	localparam logic [PADDR_W-1:0] START_ADDR_OFFSET = PADDR_W'(4 * int'(REG_START_ADDRESS));

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int unsigned        err_count;
	int unsigned        pending;
	int unsigned        cycles = 0;
	int unsigned        burst_left = 0;

	rvex_in_if  issue_ch ();
	rvex_out_if result_ch ();

	rv32i_integer_execute_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rvex_retire_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue_ch),
		.result    (result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.err_count (err_count),
		.pending   (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned style;
		int unsigned left;
		result_ch.ready = 1'b0;
		style = 0;
		left  = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				style = $urandom_range(0, 2);
				left  = $urandom_range(16, 96);
			end
			left = left - 1;
			case (style)
			0:       result_ch.ready <= 1'b1;
			1:       result_ch.ready <= 1'($urandom_range(0, 1));
			default: result_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic issue_instr(logic [MODE_W-1:0] m, logic [REG_IDX_W-1:0] rd,
		logic [REG_IDX_W-1:0] rs1, logic [REG_IDX_W-1:0] rs2, logic [IMM_W-1:0] imm);
		if (burst_left == 0) begin
			issue_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left = burst_left - 1;
		issue_ch.valid     <= 1'b1;
		issue_ch.mode      <= m;
		issue_ch.dest_reg  <= rd;
		issue_ch.src1_reg  <= rs1;
		issue_ch.src2_reg  <= rs2;
		issue_ch.immediate <= imm;
		do @(posedge clk); while (!issue_ch.ready);
	endtask

	task automatic drain();
		issue_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic run_random(int unsigned count);
		logic [MODE_W-1:0]    m;
		logic [REG_IDX_W-1:0] rs1;
		logic [REG_IDX_W-1:0] rs2;
		logic [IMM_W-1:0]     imm;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 4)
				m = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
			else
				m = MODE_W'($urandom_range(MODE_ADD, MODE_JALR));
			rs1 = REG_IDX_W'($urandom);
			rs2 = ($urandom_range(0, 3) == 0) ? rs1 : REG_IDX_W'($urandom);
			case ($urandom_range(0, 11))
			0:       imm = '0;
			1:       imm = '1;
			2:       imm = 20'h007FF;
			3:       imm = 20'h00800;
			4:       imm = 20'h80000;
			default: imm = IMM_W'($urandom);
			endcase
			issue_instr(m, REG_IDX_W'($urandom), rs1, rs2, imm);
		end
	endtask

	initial begin
		issue_ch.valid     = 1'b0;
		issue_ch.mode      = '0;
		issue_ch.dest_reg  = '0;
		issue_ch.src1_reg  = '0;
		issue_ch.src2_reg  = '0;
		issue_ch.immediate = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner operands first, then every operation against them.
		issue_instr(MODE_ADDI,  5'd1,  5'd0,  5'd0,  20'h00FFF);
		issue_instr(MODE_ADDI,  5'd2,  5'd0,  5'd0,  20'h007FF);
		issue_instr(MODE_SLLI,  5'd3,  5'd1,  5'd0,  20'hFFFFF);
		issue_instr(MODE_SRAI,  5'd4,  5'd3,  5'd0,  20'h0003F);
		issue_instr(MODE_SRLI,  5'd5,  5'd3,  5'd0,  20'h0001F);
		issue_instr(MODE_ADD,   5'd6,  5'd3,  5'd1,  20'h00000);
		issue_instr(MODE_SUB,   5'd7,  5'd0,  5'd3,  20'h00000);
		issue_instr(MODE_SLT,   5'd8,  5'd3,  5'd2,  20'h00000);
		issue_instr(MODE_SLTU,  5'd9,  5'd3,  5'd2,  20'h00000);
		issue_instr(MODE_SLL,   5'd10, 5'd2,  5'd1,  20'h00000);
		issue_instr(MODE_SRA,   5'd11, 5'd3,  5'd5,  20'h00000);
		issue_instr(MODE_SRL,   5'd12, 5'd3,  5'd1,  20'h00000);
		issue_instr(MODE_XOR,   5'd13, 5'd1,  5'd2,  20'h00000);
		issue_instr(MODE_OR,    5'd14, 5'd3,  5'd2,  20'h00000);
		issue_instr(MODE_AND,   5'd15, 5'd1,  5'd3,  20'h00000);
		issue_instr(MODE_SLTI,  5'd16, 5'd3,  5'd0,  20'h00800);
		issue_instr(MODE_SLTIU, 5'd17, 5'd2,  5'd0,  20'h00FFF);
		issue_instr(MODE_XORI,  5'd18, 5'd1,  5'd0,  20'h00800);
		issue_instr(MODE_ORI,   5'd19, 5'd3,  5'd0,  20'h007FF);
		issue_instr(MODE_ANDI,  5'd20, 5'd1,  5'd0,  20'h00800);
		issue_instr(MODE_ADDI,  5'd0,  5'd1,  5'd0,  20'h00005);
		issue_instr(MODE_BEQ,   5'd0,  5'd1,  5'd4,  20'h00800);
		issue_instr(MODE_BNE,   5'd0,  5'd0,  5'd0,  20'h00010);
		issue_instr(MODE_BLT,   5'd0,  5'd3,  5'd2,  20'h007FF);
		issue_instr(MODE_BGE,   5'd0,  5'd3,  5'd2,  20'h00004);
		issue_instr(MODE_BLTU,  5'd0,  5'd2,  5'd3,  20'h00100);
		issue_instr(MODE_BGEU,  5'd0,  5'd3,  5'd3,  20'h00002);
		issue_instr(MODE_JAL,   5'd31, 5'd0,  5'd0,  20'h80000);
		issue_instr(MODE_JAL,   5'd0,  5'd0,  5'd0,  20'h7FFFF);
		issue_instr(MODE_JALR,  5'd1,  5'd1,  5'd0,  20'h00001);
		issue_instr(MODE_UNUSED_LO, 5'd21, 5'd1, 5'd2, 20'hFFFFF);
		issue_instr(MODE_UNUSED_HI, 5'd22, 5'd3, 5'd4, 20'h00000);

		drain();
		cfg_write(START_ADDR_OFFSET, 32'hFFFF_FFFC);
		run_random(220);

		drain();
		cfg_write(START_ADDR_OFFSET, 32'h0000_0000);
		run_random(120);
		drain();
		run_random(100);

		drain();
		cfg_write(START_ADDR_OFFSET, $urandom & ~32'h3);
		run_random(110);

		drain();
		cfg_write(START_ADDR_OFFSET, 32'h0000_0003);
		run_random(100);

		drain();
		repeat (8) @(posedge clk);
		if (err_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/rvex_pkg.sv
src/rvex_in_if.sv
src/rvex_out_if.sv
src/rv32i_integer_execute_unit.sv
dv/rvex_retire_checker.sv
dv/tb_rv32i_integer_execute_unit.sv
